@@ design/signed_integer_to_radix_digits_core_defines.svh @@
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_core assertion macros
// Shared concurrent assertion forms, clocked on clk, gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_DEFINES_SVH

// same-cycle implication
`define SIRD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sird assertion failed");

// next-cycle implication
`define SIRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sird assertion failed");

`endif

@@ design/sird_pkg.sv @@
// ----------------------------------------------------------------------------
// sird_pkg
// Types and constants shared by the radix digit converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sird_pkg;

  localparam int VALUE_W       = 32;
  localparam int SYM_W         = 8;
  localparam int LEN_W         = 5;
  localparam int DIGIT_W       = 4;
  localparam int MAX_SYMBOLS   = 16;
  localparam int SYMTAB_W      = MAX_SYMBOLS * SYM_W;
  localparam int MAX_DIGITS    = 32;
  localparam int CNT_W         = 6;
  localparam int IDX_W         = 5;
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;

  // register indexes (paddr[4:3])
  localparam logic [1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

@@ design/signed_integer_to_radix_digits_core.sv @@
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_core
// Converts signed 32-bit words to text characters in a configurable radix.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one signed 32-bit word per transfer.
//   out_*  : one character byte per transfer; tlast marks the final digit.
//            A negative word gives '-' first, then digits, most significant
//            first. With a bad symbol table a word gives no characters.
//   cfg_*  : 64-bit register port. 0x00 base_length, 0x08 symbols_low,
//            0x10 symbols_high. Write only while the block is idle.
// Timing:
//   The divider takes 8 dividend bits a cycle and gives one digit per pass
//   over the magnitude; the characters ('-' first if negative) then leave at
//   one per cycle from the output register while out_tready stays high.
//   A two-entry queue lets the front take words while the back is busy.
// Reset: clears queue, sequencer, output valid flag and all config registers.
// Stall: a held output keeps its character; the back and then the queue
//   fill, after which in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_radix_digits_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,     // [31:0] value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,    // [7:0] symbol
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  import sird_pkg::*;

  logic [LEN_W-1:0]    base_length_r;
  logic [63:0]         symbols_low_r;
  logic [63:0]         symbols_high_r;
  logic [SYMTAB_W-1:0] symbols;
  logic [1:0]          reg_idx;
  logic                cfg_wr;

  logic  q_full, q_push, q_valid, q_pop;
  item_t q_in_item, q_out_item;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign symbols    = {symbols_high_r, symbols_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_length_r  <= '0;
      symbols_low_r  <= '0;
      symbols_high_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BASE_LENGTH:  base_length_r  <= cfg_pwdata[LEN_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low_r  <= cfg_pwdata;
        REG_SYMBOLS_HIGH: symbols_high_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_LENGTH:  cfg_prdata = {{(64-LEN_W){1'b0}}, base_length_r};
      REG_SYMBOLS_LOW:  cfg_prdata = symbols_low_r;
      REG_SYMBOLS_HIGH: cfg_prdata = symbols_high_r;
      default:          cfg_prdata = '0;
    endcase
  end

  sird_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .base_length (base_length_r),
    .symbols     (symbols),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in_item)
  );

  sird_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_out_item)
  );

  sird_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .radix      (base_length_r),
    .symbols    (symbols),
    .q_valid    (q_valid),
    .q_item     (q_out_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ design/sird_front.sv @@
// ----------------------------------------------------------------------------
// sird_front
// Accepts input words, checks the symbol table and forms sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module sird_front (
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [sird_pkg::VALUE_W-1:0]  in_tdata,     // [31:0] value
  input  wire logic [sird_pkg::LEN_W-1:0]    base_length,
  input  wire logic [sird_pkg::SYMTAB_W-1:0] symbols,
  input  wire logic                          q_full,
  output logic                               q_push,
  output sird_pkg::item_t                    q_item
);
  import sird_pkg::*;

  logic [SYM_W-1:0] sym [MAX_SYMBOLS];
  logic             base_ok;

  always_comb begin
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      sym[i] = symbols[i*SYM_W +: SYM_W];
    end
  end

  // every pair of symbols in use is compared in parallel
  always_comb begin
    base_ok = (base_length >= LEN_W'(2)) && (base_length <= LEN_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (LEN_W'(i) < base_length) begin
        if (sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS) begin
          base_ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if (LEN_W'(j) < base_length && sym[j] == sym[i]) begin
            base_ok = 1'b0;
          end
        end
      end
    end
  end

  assign in_tready  = !q_full;
  // with a bad table the word is taken and dropped
  assign q_push     = in_tvalid && !q_full && base_ok;
  assign q_item.neg = in_tdata[VALUE_W-1];
  assign q_item.mag = in_tdata[VALUE_W-1] ? (VALUE_W'(0) - in_tdata) : in_tdata;

endmodule

`default_nettype wire

@@ design/sird_queue.sv @@
// ----------------------------------------------------------------------------
// sird_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_integer_to_radix_digits_core_defines.svh"

module sird_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sird_pkg::item_t push_item,
  output logic                 full,
  output logic                 pop_valid,
  input  wire logic            pop,
  output sird_pkg::item_t      pop_item
);
  import sird_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CQ_W  = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_W-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CQ_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = CQ_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CQ_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `SIRD_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CQ_W'(QUEUE_DEPTH))
  `SIRD_ASSERT_IMPL(a_no_push_full, push, !full)
  `SIRD_ASSERT_IMPL(a_no_pop_empty, pop, pop_valid)

endmodule

`default_nettype wire

@@ design/sird_back.sv @@
// ----------------------------------------------------------------------------
// sird_back
// Divides the magnitude by the radix, stacks the digits, emits characters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_integer_to_radix_digits_core_defines.svh"

module sird_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [sird_pkg::LEN_W-1:0]    radix,
  input  wire logic [sird_pkg::SYMTAB_W-1:0] symbols,
  input  wire logic                          q_valid,
  input  wire sird_pkg::item_t               q_item,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [sird_pkg::SYM_W-1:0]         out_tdata,   // [7:0] symbol
  output logic                               out_tlast
);
  import sird_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  back_state_t        state_r, state_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   out_sym_r, out_sym_nxt;
  logic               out_last_r, out_last_nxt;
  logic [DIGIT_W-1:0] stack_r [MAX_DIGITS];

  logic [VALUE_W-1:0]       div_quot;
  logic [DIGIT_W-1:0]       div_rem;
  logic [BITS_PER_STEP-1:0] qbits;
  logic                     push_digit;
  logic                     load_ok;
  logic [IDX_W-1:0]         emit_idx;
  logic [DIGIT_W-1:0]       emit_digit;
  logic [SYM_W-1:0]         emit_sym;

  // restoring long division, eight dividend bits per cycle
  always_comb begin
    logic [DIGIT_W:0] t;
    logic [DIGIT_W-1:0] r;
    r     = rem_r;
    qbits = '0;
    for (int k = BITS_PER_STEP - 1; k >= 0; k--) begin
      t = {r, mag_r[VALUE_W - BITS_PER_STEP + k]};
      if (t >= radix) begin
        qbits[k] = 1'b1;
        r = DIGIT_W'(t - radix);
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end
    div_rem  = r;
    div_quot = {mag_r[VALUE_W-BITS_PER_STEP-1:0], qbits};
  end

  assign load_ok    = !out_valid_r || out_tready;
  assign emit_idx   = IDX_W'(cnt_r - 1'b1);
  assign emit_digit = stack_r[emit_idx];
  assign emit_sym   = symbols[{emit_digit, 3'b000} +: SYM_W];

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    push_digit    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          mag_nxt   = q_item.mag;
          neg_nxt   = q_item.neg;
          cnt_nxt   = '0;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        mag_nxt  = div_quot;
        rem_nxt  = div_rem;
        step_nxt = STEP_W'(step_r + 1'b1);
        if (step_r == STEP_LAST) begin
          push_digit = 1'b1;
          cnt_nxt    = CNT_W'(cnt_r + 1'b1);
          rem_nxt    = '0;
          if (div_quot == '0 || cnt_r == CNT_W'(MAX_DIGITS - 1)) begin
            state_nxt = neg_r ? BK_SIGN : BK_EMIT;
          end
        end
      end
      BK_SIGN: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = emit_sym;
          out_last_nxt  = (cnt_r == CNT_W'(1));
          cnt_nxt       = CNT_W'(cnt_r - 1'b1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    if (push_digit) begin
      stack_r[cnt_r[IDX_W-1:0]] <= div_rem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

  `SIRD_ASSERT_IMPL(a_div_room, state_r == BK_DIV, cnt_r < CNT_W'(MAX_DIGITS))
  `SIRD_ASSERT_IMPL(a_emit_has_digit, state_r == BK_EMIT, cnt_r != '0)
  `SIRD_ASSERT_NEXT(a_idle_starts, state_r == BK_IDLE && q_valid, state_r == BK_DIV)

endmodule

`default_nettype wire

@@ tb/sv/sird_digit_checker.sv @@
// ----------------------------------------------------------------------------
// sird_digit_checker
// Watches the register port and both streams of the radix digit converter,
// keeps its own copy of the symbol table, expands every accepted word into
// the characters it must produce and compares them in order as they leave.
// ----------------------------------------------------------------------------
module sird_digit_checker
  import sird_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] value
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,    // [7:0] symbol
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } char_t;

  logic [LEN_W-1:0] radix_len;
  logic [63:0]      table_low;
  logic [63:0]      table_high;
  char_t            expected_chars[$];
  int               fails = 0;

  function automatic logic [SYM_W-1:0] symbol_of(input int unsigned d);
    if (d < 8) return table_low[8*d +: 8];
    return table_high[8*(d-8) +: 8];
  endfunction

  function automatic bit table_usable();
    int unsigned n;
    int unsigned i;
    int unsigned j;
    logic [SYM_W-1:0] s;
    n = radix_len;
    if (n < 2 || n > MAX_SYMBOLS) return 1'b0;
    for (i = 0; i < n; i++) begin
      s = symbol_of(i);
      if (s == CHAR_PLUS || s == CHAR_MINUS) return 1'b0;
      for (j = i + 1; j < n; j++)
        if (symbol_of(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // sign first, then digits most significant first; magnitude of the most
  // negative word still fits since 0 - raw is taken as unsigned
  task automatic expand_value(input logic [31:0] raw);
    logic [31:0]          mag;
    logic [31:0]          radix;
    logic [DIGIT_W-1:0]   digits[$];
    char_t                c;
    int                   i;
    if (!table_usable()) return;
    mag   = raw[31] ? (32'd0 - raw) : raw;
    radix = {27'd0, radix_len};
    do begin
      digits.push_front(DIGIT_W'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (raw[31]) begin
      c.symbol = CHAR_MINUS;
      c.last   = 1'b0;
      expected_chars.push_back(c);
    end
    for (i = 0; i < digits.size(); i++) begin
      c.symbol = symbol_of(digits[i]);
      c.last   = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endtask

  // a word taken at the same edge as a register write sees the old table
  always @(posedge clk) begin
    char_t want;
    if (!rst_n) begin
      radix_len  = '0;
      table_low  = '0;
      table_high = '0;
      expected_chars.delete();
    end else begin
      if (in_tvalid && in_tready) expand_value(in_tdata);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_BASE_LENGTH:  radix_len  = cfg_pwdata[LEN_W-1:0];
          REG_SYMBOLS_LOW:  table_low  = cfg_pwdata;
          REG_SYMBOLS_HIGH: table_high = cfg_pwdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character: symbol 0x%02h last %0b", out_tdata, out_tlast);
          fails++;
        end else begin
          want = expected_chars.pop_front();
          if (want.symbol !== out_tdata) begin
            $error("symbol mismatch: expected 0x%02h actual 0x%02h", want.symbol, out_tdata);
            fails++;
          end
          if (want.last !== out_tlast) begin
            $error("last mismatch: expected %0b actual %0b", want.last, out_tlast);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_chars.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Regression for the radix digit converter: directed symbol tables and words
// at the edges, then random tables and words under changing back pressure.
// ----------------------------------------------------------------------------
module tb;
  import sird_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 600;
  localparam int HOLD_CYCLES   = 600;
  localparam int QUIET_LIMIT   = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // [31:0] value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] symbol
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_req_cnt = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  signed_integer_to_radix_digits_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  sird_digit_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("signed_integer_to_radix_digits_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // input stream goes quiet for the whole register access
  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
    in_tvalid   <= 1'b0;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper pwdata bits of the length register carry junk on purpose
  task automatic load_table(input logic [4:0] len, input logic [63:0] lo,
                            input logic [63:0] hi);
    cfg_write(REG_BASE_LENGTH, {$urandom, 27'($urandom), len});
    cfg_write(REG_SYMBOLS_LOW, lo);
    cfg_write(REG_SYMBOLS_HIGH, hi);
  endtask

  task automatic send_value(input logic [31:0] v);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // extra cycles cover words still in flight that yield no characters
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 300);
      3:       return 32'd0 - $urandom_range(1, 300);
      4: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0;
          3:       return 32'hffff_ffff;
          default: return 32'h1;
        endcase
      end
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // mostly valid tables; some short, long, repeating or carrying a sign
  task automatic load_random_table(input bit radix2);
    logic [7:0]  syms[16];
    logic [7:0]  b;
    logic [4:0]  len;
    logic [63:0] lo;
    logic [63:0] hi;
    int          i;
    int          j;
    int          pos;
    bit          clash;
    len = radix2 ? 5'd2 : 5'($urandom_range(2, 16));
    for (i = 0; i < 16; i++) begin
      if (i < len) begin
        do begin
          b = 8'($urandom);
          clash = (b == CHAR_PLUS) || (b == CHAR_MINUS);
          for (j = 0; j < i; j++)
            if (syms[j] == b) clash = 1'b1;
        end while (clash);
        syms[i] = b;
      end else begin
        syms[i] = 8'($urandom);
      end
    end
    if (!radix2) begin
      case ($urandom_range(0, 9))
        6: len = 5'($urandom_range(0, 1));
        7: len = 5'($urandom_range(17, 31));
        8: begin
          pos = $urandom_range(1, len - 1);
          syms[pos] = syms[$urandom_range(0, pos - 1)];
        end
        9: syms[$urandom_range(0, len - 1)] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
        default: ;
      endcase
    end
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = syms[i];
      hi[8*i +: 8] = syms[i + 8];
    end
    load_table(len, lo, hi);
  endtask

  initial begin
    int p;
    int c;
    int k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table after reset is empty: no characters
    send_value(32'd5);
    send_value(32'h8000_0000);
    settle();

    // decimal, with a junk write to the unmapped register
    load_table(5'd10, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    cfg_write(REG_UNUSED, {$urandom, $urandom});
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'd10);
    send_value(32'hffff_fff6);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'hc521_974f);
    settle();

    // radix 2: longest output, sign plus 32 digits
    load_table(5'd2, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    send_value(32'hffff_ffff);
    settle();

    // radix 16: all sixteen table entries in use
    load_table(5'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value(32'h7edc_ba98);
    send_value(32'h8765_4321);
    send_value(32'h0123_4567);
    settle();

    // zero byte as a digit symbol; bytes past the length repeat and hold '-' and '+'
    load_table(5'd3, 64'h2d2d_2d2d_2d5a_4100, 64'h2b2b_2b2b_2b2b_2b2b);
    send_value(32'd0);
    send_value(32'hffff_fffb);
    settle();

    // bad tables: '-' as the last symbol in use, repeat, '+', too short, too long
    load_table(5'd4, 64'h0000_0000_2d32_3130, 64'h0);
    send_value(32'd7);
    cfg_write(REG_SYMBOLS_LOW, 64'h0000_0000_3132_3130);
    send_value(32'd7);
    cfg_write(REG_SYMBOLS_LOW, 64'h0000_0000_332b_3130);
    send_value(32'd7);
    load_table(5'd1, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value(32'd0);
    cfg_write(REG_BASE_LENGTH, 64'd17);
    send_value(32'd9);
    cfg_write(REG_BASE_LENGTH, 64'd31);
    send_value(32'hffff_ffff);
    settle();

    for (p = 0; p < 3; p++) begin
      in_idle_pct  = (p == 0) ? 18 : (p == 1) ? 80 : 0;
      out_idle_pct = (p == 0) ? 80 : (p == 1) ? 18 : 0;
      for (c = 0; c < 3; c++) begin
        load_random_table(p == 2 && c == 1);
        // receiver stops while words keep coming, so the input backs up
        if (p == 2 && c == 1) hold_req_cnt <= hold_req_cnt + 1;
        for (k = 0; k < 10; k++) send_value(random_value());
        settle();
      end
    end

    if (fail_count == 0)
      $display("signed_integer_to_radix_digits_core regression: pass");
    else
      $display("signed_integer_to_radix_digits_core regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/sird_pkg.sv
design/sird_front.sv
design/sird_queue.sv
design/sird_back.sv
design/signed_integer_to_radix_digits_core.sv
tb/sv/sird_digit_checker.sv
tb/sv/tb.sv
